@@ rtl/core/pdcd_pkg.sv @@
package pdcd_pkg;

  localparam int unsigned EVENT_BYTES  = 4;
  localparam int unsigned NUM_CHANNELS = 4;

  // Payload position and counter widths.
  localparam int unsigned IDX_W  = (EVENT_BYTES > 1) ? $clog2(EVENT_BYTES) : 1;
  localparam int unsigned CNT_W  = $clog2(EVENT_BYTES + 1);
  localparam int unsigned SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Packet queue between the parser and the emitter.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] START_BYTE_RST    = 8'h7E;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd5;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic {
    REG_START_BYTE    = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic [1:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] event_byte;
    logic [4:0] byte_index;
    logic [7:0] packet_id;
    logic [1:0] source_channel;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] timeout_ticks;
  } cfg_t;

  // One accepted packet as it waits for emission.
  typedef struct packed {
    logic [EVENT_BYTES-1:0][7:0] payload;
    logic [7:0]                  packet_id;
    logic [1:0]                  channel;
  } pkt_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Channel folded onto the id store; the channel is narrow, so a few
  // conditional subtractions do the reduction.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] ch);
    logic [4:0] v;
    v = {3'b000, ch};
    for (int i = 0; i < 4; i++) begin
      if (v >= 5'(NUM_CHANNELS)) begin
        v = v - 5'(NUM_CHANNELS);
      end
    end
    return v[SLOT_W-1:0];
  endfunction

endpackage

@@ rtl/core/packet_deframer_checksum_dedup.sv @@
// Channel  | Direction | Handshake            | Payload
// input    | in        | push / full          | in_item_i  (operation, rx_byte, channel)
// result   | out       | empty / pop          | out_item_o (event_byte .. last)
// config   | in        | cfg_we_i, cfg_idx_i  | cfg_data_i (start_byte, timeout_ticks)
//
// The parser takes one item per cycle while full is low; full rises only when
// both entries of the packet queue are occupied.
// An accepted packet enters the packet queue with its checksum byte, then the result
// register, and gives one result per cycle while pop is high, EVENT_BYTES in all.
// The emitter reads the queue head one payload byte per cycle while pop is high,
// which sets the sustained output rate. Reset is asynchronous and clears the parser,
// the id store, the queue and the result register; there is no clearing pass.
module packet_deframer_checksum_dedup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  pdcd_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output pdcd_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);

  pdcd_pkg::cfg_t     cfg_q;
  pdcd_pkg::pkt_t     pkt_new, pkt_head;
  pdcd_pkg::q_stat_t  q_stat;
  logic               accept;
  logic               q_push;
  logic               q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= pdcd_pkg::START_BYTE_RST;
      cfg_q.timeout_ticks <= pdcd_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdcd_pkg::REG_START_BYTE:    cfg_q.start_byte    <= cfg_data_i;
        pdcd_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full   = q_stat.full;
  assign accept = push && !full;

  pdcd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (q_push),
    .pkt_o    (pkt_new)
  );

  pdcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pkt_i  (pkt_new),
    .pop_i  (q_pop),
    .head_o (pkt_head),
    .stat_o (q_stat)
  );

  pdcd_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (pkt_head),
    .q_stat_i (q_stat),
    .deq_o    (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .item_o   (out_item_o)
  );

  // A packet is only ever handed to the queue when there is room for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("packet pushed into a full queue");

  // The final result of a run sits at the last payload position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && out_item_o.last) |->
      (out_item_o.byte_index == 5'(pdcd_pkg::EVENT_BYTES - 1)))
    else $error("last flag on the wrong payload position");

  // The rest of a run is still queued, so taking a non-final result refills at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (pop && !empty && !out_item_o.last) |=> !empty)
    else $error("gap inside a result run");

  // Tick items never produce a queued packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      q_push |-> (accept && (in_item_i.operation == pdcd_pkg::OP_BYTE)))
    else $error("packet queued without an accepted byte");

endmodule

@@ rtl/core/pdcd_front.sv @@
module pdcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdcd_pkg::cfg_t      cfg_i,
  input  logic                accept_i,
  input  pdcd_pkg::in_item_t  item_i,
  output logic                push_o,
  output pdcd_pkg::pkt_t      pkt_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ID      = 2'd2,
    PH_CHECK   = 2'd3
  } phase_e;

  phase_e                           phase_q, phase_d;
  logic [7:0]                       sum_q, sum_d;
  logic [pdcd_pkg::CNT_W-1:0]       count_q, count_d;
  logic [7:0]                       held_id_q, held_id_d;
  logic [7:0]                       tmo_q, tmo_d;
  logic [7:0]                       last_id_q [pdcd_pkg::NUM_CHANNELS];
  logic [7:0]                       store_q [pdcd_pkg::EVENT_BYTES];
  logic [pdcd_pkg::SLOT_W-1:0]      slot;
  logic [7:0]                       tmo_dec;
  logic                             is_byte;
  logic                             good;

  assign is_byte = accept_i && (item_i.operation == pdcd_pkg::OP_BYTE);
  assign slot    = pdcd_pkg::slot_of(item_i.channel);
  assign tmo_dec = (tmo_q != 8'd0) ? tmo_q - 8'd1 : 8'd0;
  assign good    = (sum_q == item_i.rx_byte) && (last_id_q[slot] != held_id_q);

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    count_d   = count_q;
    held_id_d = held_id_q;
    tmo_d     = tmo_q;
    push_o    = 1'b0;
    if (accept_i) begin
      if (item_i.operation == pdcd_pkg::OP_TICK) begin
        tmo_d = tmo_dec;
        if ((phase_q != PH_IDLE) && (tmo_dec == 8'd0)) begin
          phase_d = PH_IDLE;
        end
      end else begin
        tmo_d = cfg_i.timeout_ticks;
        unique case (phase_q)
          PH_IDLE: begin
            if (item_i.rx_byte == cfg_i.start_byte) begin
              phase_d = PH_PAYLOAD;
              sum_d   = 8'd0;
              count_d = '0;
            end
          end
          PH_PAYLOAD: begin
            sum_d   = sum_q + item_i.rx_byte;
            count_d = count_q + 1'b1;
            if (count_d >= pdcd_pkg::CNT_W'(pdcd_pkg::EVENT_BYTES)) begin
              phase_d = PH_ID;
            end
          end
          PH_ID: begin
            held_id_d = item_i.rx_byte;
            sum_d     = sum_q + item_i.rx_byte;
            phase_d   = PH_CHECK;
          end
          PH_CHECK: begin
            phase_d = PH_IDLE;
            push_o  = good;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      sum_q     <= 8'd0;
      count_q   <= '0;
      held_id_q <= 8'd0;
      tmo_q     <= 8'd0;
      for (int c = 0; c < pdcd_pkg::NUM_CHANNELS; c++) begin
        last_id_q[c] <= 8'd0;
      end
    end else begin
      phase_q   <= phase_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      held_id_q <= held_id_d;
      tmo_q     <= tmo_d;
      if (push_o) begin
        last_id_q[slot] <= held_id_q;
      end
    end
  end

  // Each payload register is loaded when the count reaches its position.
  always_ff @(posedge clk_i) begin
    if (is_byte && (phase_q == PH_PAYLOAD)) begin
      for (int i = 0; i < pdcd_pkg::EVENT_BYTES; i++) begin
        if (count_q == pdcd_pkg::CNT_W'(i)) begin
          store_q[i] <= item_i.rx_byte;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < pdcd_pkg::EVENT_BYTES; i++) begin
      pkt_o.payload[i] = store_q[i];
    end
    pkt_o.packet_id = held_id_q;
    pkt_o.channel   = item_i.channel;
  end

endmodule

@@ rtl/core/pdcd_queue.sv @@
module pdcd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pdcd_pkg::pkt_t     pkt_i,
  input  logic               pop_i,
  output pdcd_pkg::pkt_t     head_o,
  output pdcd_pkg::q_stat_t  stat_o
);

  pdcd_pkg::pkt_t                mem_q [pdcd_pkg::QDEPTH];
  logic [pdcd_pkg::QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [pdcd_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == pdcd_pkg::QCNT_W'(pdcd_pkg::QDEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == pdcd_pkg::QPTR_W'(pdcd_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == pdcd_pkg::QPTR_W'(pdcd_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

endmodule

@@ rtl/core/pdcd_emit.sv @@
module pdcd_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdcd_pkg::pkt_t      head_i,
  input  pdcd_pkg::q_stat_t   q_stat_i,
  output logic                deq_o,
  input  logic                pop_i,
  output logic                empty_o,
  output pdcd_pkg::out_item_t item_o
);

  logic                         valid_q;
  logic [pdcd_pkg::IDX_W-1:0]   idx_q;
  pdcd_pkg::out_item_t          item_q;
  logic                         load;
  logic                         at_end;

  // Output register refills when empty or taken and a packet waits.
  assign load   = (!valid_q || pop_i) && !q_stat_i.empty;
  assign at_end = (idx_q == pdcd_pkg::IDX_W'(pdcd_pkg::EVENT_BYTES - 1));
  assign deq_o  = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? '0 : idx_q + 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.event_byte     <= head_i.payload[idx_q];
      item_q.byte_index     <= 5'(idx_q);
      item_q.packet_id      <= head_i.packet_id;
      item_q.source_channel <= head_i.channel;
      item_q.last           <= at_end;
    end
  end

  assign empty_o = !valid_q;
  assign item_o  = item_q;

endmodule

@@ tb/tb_packet_deframer_checksum_dedup.sv @@
`timescale 1ns / 1ps

module tb_packet_deframer_checksum_dedup;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BODY,
    ST_ID,
    ST_SUM
  } parse_st_e;

  // Tracks the deframer state and holds the event bytes it should emit.
  class event_predictor;
    logic [7:0]          start_byte;
    logic [7:0]          timeout_ticks;
    parse_st_e           state;
    logic [7:0]          sum;
    int                  count;
    logic [7:0]          held_id;
    logic [7:0]          body [pdcd_pkg::EVENT_BYTES];
    logic [7:0]          last_id [pdcd_pkg::NUM_CHANNELS];
    logic [7:0]          tmo_count;
    pdcd_pkg::out_item_t pending_events [$];
    int                  errors;

    function new();
      start_byte    = pdcd_pkg::START_BYTE_RST;
      timeout_ticks = pdcd_pkg::TIMEOUT_TICKS_RST;
      state         = ST_IDLE;
      sum           = '0;
      count         = 0;
      held_id       = '0;
      tmo_count     = '0;
      errors        = 0;
      foreach (last_id[i]) last_id[i] = '0;
    endfunction

    function void set_reg(pdcd_pkg::reg_idx_e idx, logic [7:0] value);
      case (idx)
        pdcd_pkg::REG_START_BYTE:    start_byte = value;
        pdcd_pkg::REG_TIMEOUT_TICKS: timeout_ticks = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void note_item(pdcd_pkg::in_item_t it);
      pdcd_pkg::out_item_t ev;
      int                  slot;
      if (pdcd_pkg::op_e'(it.operation) == pdcd_pkg::OP_TICK) begin
        if (tmo_count != 0) tmo_count--;
        if (state != ST_IDLE && tmo_count == 0) state = ST_IDLE;
        return;
      end
      tmo_count = timeout_ticks;
      case (state)
        ST_IDLE: begin
          if (it.rx_byte == start_byte) begin
            state = ST_BODY;
            sum   = '0;
            count = 0;
          end
        end
        ST_BODY: begin
          body[count] = it.rx_byte;
          sum         = sum + it.rx_byte;
          count++;
          if (count >= pdcd_pkg::EVENT_BYTES) state = ST_ID;
        end
        ST_ID: begin
          held_id = it.rx_byte;
          sum     = sum + it.rx_byte;
          state   = ST_SUM;
        end
        default: begin
          state = ST_IDLE;
          slot  = int'(it.channel) % pdcd_pkg::NUM_CHANNELS;
          // Bad sums and ids already held for the channel leave no trace.
          if (sum == it.rx_byte && last_id[slot] != held_id) begin
            last_id[slot] = held_id;
            for (int i = 0; i < pdcd_pkg::EVENT_BYTES; i++) begin
              ev.event_byte     = body[i];
              ev.byte_index     = 5'(i);
              ev.packet_id      = held_id;
              ev.source_channel = it.channel;
              ev.last           = (i == pdcd_pkg::EVENT_BYTES - 1);
              pending_events.push_back(ev);
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_event(pdcd_pkg::out_item_t got);
      pdcd_pkg::out_item_t want;
      if (pending_events.size() == 0) begin
        $error("event_byte: expected no item, got %0d", got.event_byte);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      compare_field("event_byte", want.event_byte, got.event_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("packet_id", want.packet_id, got.packet_id);
      compare_field("source_channel", want.source_channel, got.source_channel);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  pdcd_pkg::in_item_t  in_item;
  logic                empty;
  logic                pop;
  pdcd_pkg::out_item_t out_item;
  logic                cfg_we;
  logic                cfg_idx;
  logic [7:0]          cfg_data;

  event_predictor pred;
  int             items_sent;
  int             stall_cycles;
  bit             sender_flat;
  int             run_left [2];

  packet_deframer_checksum_dedup dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Side 0 is the sender, side 1 the receiver; now and then a run of zero gaps.
  function automatic int draw_gap(int side);
    if (run_left[side] > 0) begin
      run_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run_left[side] = $urandom_range(5, 20);
    return $urandom_range(0, 9);
  endfunction

  task automatic send_item(pdcd_pkg::in_item_t it);
    int gap;
    gap = sender_flat ? 0 : draw_gap(0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    pred.note_item(it);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b, logic [1:0] ch);
    pdcd_pkg::in_item_t it;
    it.operation = pdcd_pkg::OP_BYTE;
    it.rx_byte   = b;
    it.channel   = ch;
    send_item(it);
  endtask

  task automatic send_tick();
    pdcd_pkg::in_item_t it;
    it.operation = pdcd_pkg::OP_TICK;
    it.rx_byte   = 8'($urandom);
    it.channel   = 2'($urandom);
    send_item(it);
  endtask

  task automatic maybe_ticks(bit ticks_ok);
    if (ticks_ok && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 2)) send_tick();
    end
  endtask

  task automatic send_frame(logic [pdcd_pkg::EVENT_BYTES-1:0][7:0] pl, logic [7:0] id,
                            logic [1:0] ch, bit good, bit ticks_ok);
    logic [7:0] sum;
    sum = '0;
    send_byte(pred.start_byte, 2'($urandom));
    for (int i = 0; i < pdcd_pkg::EVENT_BYTES; i++) begin
      maybe_ticks(ticks_ok);
      send_byte(pl[i], 2'($urandom));
      sum = sum + pl[i];
    end
    maybe_ticks(ticks_ok);
    send_byte(id, 2'($urandom));
    sum = sum + id;
    maybe_ticks(ticks_ok);
    send_byte(good ? sum : sum + 8'($urandom_range(1, 255)), ch);
  endtask

  task automatic send_packet(bit good, bit repeat_id);
    logic [pdcd_pkg::EVENT_BYTES-1:0][7:0] pl;
    logic [1:0]                            ch;
    logic [7:0]                            id;
    ch = 2'($urandom);
    foreach (pl[i]) pl[i] = 8'($urandom);
    id = repeat_id ? pred.last_id[ch] : pred.last_id[ch] + 8'($urandom_range(1, 255));
    send_frame(pl, id, ch, good, 1'b1);
  endtask

  task automatic random_item();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 13) begin
      send_packet(kind > 1, kind == 2);
    end else if (kind < 16) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 2'($urandom));
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 3)) send_tick();
    end else begin
      // A packet cut short; whatever follows is parsed as its remainder.
      send_byte(pred.start_byte, 2'($urandom));
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 2'($urandom));
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pred.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(pdcd_pkg::reg_idx_e idx, logic [7:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    pred.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int target;
    push         = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = 1'b0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    items_sent   = 0;
    stall_cycles = 0;
    sender_flat  = 1'b0;
    run_left     = '{0, 0};
    pred         = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(pdcd_pkg::REG_START_BYTE, pdcd_pkg::START_BYTE_RST);
    write_reg(pdcd_pkg::REG_TIMEOUT_TICKS, pdcd_pkg::TIMEOUT_TICKS_RST);

    // A stray byte, then an id of zero on a fresh channel, which counts as a repeat.
    send_byte(8'h00, 2'd0);
    send_frame({8'h80, 8'h7E, 8'hFF, 8'h00}, 8'h00, 2'd0, 1'b1, 1'b0);
    send_frame({pdcd_pkg::EVENT_BYTES{8'hFF}}, 8'hFF, 2'd3, 1'b1, 1'b0);
    // Timeout in mid-packet, then one more tick on a counter already at zero.
    send_byte(pred.start_byte, 2'd1);
    send_byte(8'h55, 2'd1);
    repeat (6) send_tick();
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(pdcd_pkg::REG_START_BYTE, 8'h00);
          write_reg(pdcd_pkg::REG_TIMEOUT_TICKS, 8'd1);
        end
        1: begin
          write_reg(pdcd_pkg::REG_START_BYTE, 8'hFF);
          write_reg(pdcd_pkg::REG_TIMEOUT_TICKS, 8'd0);
        end
        2: begin
          write_reg(pdcd_pkg::REG_START_BYTE, 8'($urandom));
          write_reg(pdcd_pkg::REG_TIMEOUT_TICKS, 8'd255);
        end
        default: begin
          write_reg(pdcd_pkg::REG_START_BYTE, 8'($urandom));
          write_reg(pdcd_pkg::REG_TIMEOUT_TICKS, 8'($urandom_range(1, 255)));
        end
      endcase
      target = items_sent + 13;
      while (items_sent < target) random_item();
      drain();
    end

    // Hold the receiver off while good packets arrive back to back, so the
    // packet queue fills and the input stalls.
    stall_cycles = 300;
    sender_flat  = 1'b1;
    repeat (6) send_packet(1'b1, 1'b0);
    sender_flat = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (pred.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int gap;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_cycles > 0) begin
        pop <= 1'b0;
        repeat (stall_cycles) @(posedge clk);
        stall_cycles = 0;
      end
      gap = draw_gap(1);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      pred.check_event(out_item);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
